FILE: src/arc_pkg.sv
// Shared types, constants and codes of the address resolver cache.
package arc_pkg;

	localparam int Entries = 8;
	localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int CntW = $clog2(Entries + 1);
	localparam int MaxOut = 8;
	localparam int OutCntW = $clog2(MaxOut + 1);
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		FN_RESOLVE = 2'd0,
		FN_RESPONSE = 2'd1,
		FN_TICK = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_INVALID = 2'd0,
		ST_QUERY = 2'd1,
		ST_CACHED = 2'd2,
		ST_UNUSED = 2'd3
	} ent_state_t;

	localparam logic [1:0] KIND_ANSWER = 2'd0;
	localparam logic [1:0] KIND_RESOLVED = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_PENDING = 2'd1;
	localparam logic [1:0] STAT_DROP = 2'd2;
	localparam logic [1:0] STAT_NOROOM = 2'd3;

	localparam logic [1:0] CFG_QWAIT = 2'd0;
	localparam logic [1:0] CFG_RWAIT = 2'd1;
	localparam logic [1:0] CFG_INV_SID = 2'd2;
	localparam logic [1:0] CFG_INV_NET = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic lookup_key;
		logic [15:0] target_sid;
		logic [15:0] target_netid;
		logic [63:0] target_uid;
		logic [15:0] att_sid;
		logic [15:0] att_netid;
		logic has_attach;
	} req_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_EMIT
	} bk_state_t;

endpackage

FILE: src/arc_front.sv
// Front part: accepts input beats, drops ignored ones and queues the rest.
module arc_front
	import arc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_req,
	input logic [15:0] inv_sid,
	input logic [15:0] inv_net,
	output logic q_valid,
	input logic q_ready,
	output req_t q_req
);

	req_t mem_q [QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop, keep;

	// Classify: unknown function and bad attach responses are dropped here
	always_comb begin
		keep = 1'b1;
		if (in_req.func == FN_NONE)
			keep = 1'b0;
		if (in_req.func == FN_RESPONSE && in_req.has_attach &&
		    (in_req.att_sid == inv_sid || in_req.att_netid == inv_net))
			keep = 1'b0;
	end

	assign in_ready = (cnt_q != 2'(QDepth));
	assign push = in_valid && in_ready && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= in_req;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'(QDepth) |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDepth)) else $error("fill count out of range");
`endif

endmodule

FILE: src/arc_back.sv
// Back part: scans entries one a cycle unless a tick stalls and emits result beats.
module arc_back
	import arc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input req_t q_req,
	input logic [7:0] qwait,
	input logic [7:0] rwait,
	input logic [15:0] inv_sid,
	input logic [15:0] inv_net,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [1:0] status,
	output logic send_query,
	output logic [2:0] entry_index,
	output logic [15:0] out_target_sid,
	output logic [15:0] out_target_netid,
	output logic [63:0] out_target_uid,
	output logic [15:0] out_att_sid,
	output logic [15:0] out_att_netid,
	output logic last
);

	ent_state_t st_q [Entries];
	logic [63:0] ueid_q [Entries];
	logic [15:0] sid_q [Entries];
	logic [15:0] net_q [Entries];
	logic [15:0] asid_q [Entries];
	logic [15:0] anet_q [Entries];
	logic [7:0] wait_q [Entries];
	logic [7:0] retry_q [Entries];

	bk_state_t state_q, state_d;
	req_t req_q;
	logic [CntW-1:0] pos_q;
	logic [IdxW-1:0] idx;
	logic [IdxW-1:0] free_q;
	logic free_vld_q;
	logic [OutCntW-1:0] nout_q;
	logic pend_q;
	logic [IdxW-1:0] pidx_q;

	// Output register
	logic ov_q;
	logic [1:0] kind_q, stat_q;
	logic send_q, last_q;
	logic [2:0] eidx_q;
	logic [15:0] osid_q, onet_q, oasid_q, oanet_q;
	logic [63:0] oueid_q;

	logic scan_end, hit_res, hit_node, hit_ueid, valid_e;
	logic tk_report, tk_stall;
	logic [7:0] wdec;

	assign idx = pos_q[IdxW-1:0];
	assign scan_end = (pos_q == CntW'(Entries));
	assign valid_e = !scan_end && (st_q[idx] != ST_INVALID);
	assign hit_res = valid_e && (req_q.lookup_key ? (ueid_q[idx] == req_q.target_uid)
		: (net_q[idx] == req_q.target_netid && sid_q[idx] == req_q.target_sid));
	assign hit_node = valid_e && req_q.has_attach && sid_q[idx] == req_q.target_sid &&
		net_q[idx] == req_q.target_netid;
	assign hit_ueid = valid_e && (ueid_q[idx] == req_q.target_uid);
	assign wdec = wait_q[idx] - 8'd1;

	// A timeout to report; it waits while an earlier held beat cannot move on
	assign tk_report = !scan_end && st_q[idx] == ST_QUERY && wait_q[idx] != 8'd0 &&
		wdec == 8'd0 && nout_q != OutCntW'(MaxOut);
	assign tk_stall = tk_report && pend_q && ov_q && !out_ready;

	assign q_ready = (state_q == BK_IDLE);
	assign out_valid = ov_q;
	assign kind = kind_q;
	assign status = stat_q;
	assign send_query = send_q;
	assign entry_index = eidx_q;
	assign out_target_sid = osid_q;
	assign out_target_netid = onet_q;
	assign out_target_uid = oueid_q;
	assign out_att_sid = oasid_q;
	assign out_att_netid = oanet_q;
	assign last = last_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (q_valid) state_d = BK_SCAN;
			BK_SCAN: begin
				if (req_q.func == FN_RESOLVE) begin
					if (hit_res || scan_end) state_d = BK_EMIT;
				end else if (req_q.func == FN_RESPONSE) begin
					if (hit_node || hit_ueid || scan_end) state_d = BK_EMIT;
				end else if (scan_end) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: if (!ov_q || out_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	// Scan the table, update entries and fill the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Entries; i++) begin
				st_q[i] <= ST_INVALID;
				ueid_q[i] <= '0;
				sid_q[i] <= '0;
				net_q[i] <= '0;
				asid_q[i] <= '0;
				anet_q[i] <= '0;
				wait_q[i] <= '0;
				retry_q[i] <= '0;
			end
			ov_q <= 1'b0;
			pos_q <= '0;
			free_q <= '0;
			free_vld_q <= 1'b0;
			nout_q <= '0;
			pend_q <= 1'b0;
			pidx_q <= '0;
			kind_q <= '0; stat_q <= '0; send_q <= 1'b0; last_q <= 1'b0;
			eidx_q <= '0; osid_q <= '0; onet_q <= '0; oueid_q <= '0;
			oasid_q <= '0; oanet_q <= '0;
			req_q <= '0;
		end else begin
			if (ov_q && out_ready)
				ov_q <= 1'b0;
			unique case (state_q)
				BK_IDLE: begin
					if (q_valid) begin
						req_q <= q_req;
						pos_q <= '0;
						free_vld_q <= 1'b0;
						nout_q <= '0;
						pend_q <= 1'b0;
					end
				end
				BK_SCAN: begin
					if (req_q.func == FN_RESOLVE) begin
						if (!hit_res && !scan_end) begin
							if (!valid_e && !free_vld_q) begin
								free_q <= idx;
								free_vld_q <= 1'b1;
							end
							pos_q <= pos_q + CntW'(1);
						end
					end else if (req_q.func == FN_RESPONSE) begin
						if (!hit_node && !hit_ueid && !scan_end)
							pos_q <= pos_q + CntW'(1);
					end else begin
						// Tick: count one entry down per cycle unless stalled, hold one timeout beat back
						if (!scan_end && !tk_stall) begin
							if (st_q[idx] == ST_QUERY) begin
								if (wait_q[idx] != 8'd0) begin
									wait_q[idx] <= wdec;
									if (wdec == 8'd0)
										retry_q[idx] <= rwait;
								end else if (retry_q[idx] != 8'd0) begin
									retry_q[idx] <= retry_q[idx] - 8'd1;
								end
							end
							if (tk_report) begin
								nout_q <= nout_q + OutCntW'(1);
								pend_q <= 1'b1;
								pidx_q <= idx;
								// Release the held beat, it is not the last one
								if (pend_q) begin
									ov_q <= 1'b1;
									last_q <= 1'b0;
									kind_q <= KIND_TIMEOUT;
									stat_q <= STAT_DROP;
									send_q <= 1'b0;
									eidx_q <= 3'(pidx_q);
									osid_q <= sid_q[pidx_q];
									onet_q <= net_q[pidx_q];
									oueid_q <= ueid_q[pidx_q];
									oasid_q <= asid_q[pidx_q];
									oanet_q <= anet_q[pidx_q];
								end
							end
							pos_q <= pos_q + CntW'(1);
						end
					end
				end
				BK_EMIT: begin
					if (!ov_q || out_ready) begin
						if (req_q.func == FN_RESOLVE) begin
							ov_q <= 1'b1;
							last_q <= 1'b1;
							kind_q <= KIND_ANSWER;
							send_q <= 1'b0;
							if (scan_end && !free_vld_q) begin
								stat_q <= STAT_NOROOM;
								eidx_q <= '0; osid_q <= '0; onet_q <= '0;
								oueid_q <= '0; oasid_q <= '0; oanet_q <= '0;
							end else if (scan_end) begin
								st_q[free_q] <= ST_QUERY;
								ueid_q[free_q] <= req_q.target_uid;
								sid_q[free_q] <= req_q.target_sid;
								net_q[free_q] <= req_q.target_netid;
								asid_q[free_q] <= req_q.att_sid;
								anet_q[free_q] <= req_q.att_netid;
								wait_q[free_q] <= qwait;
								retry_q[free_q] <= rwait;
								stat_q <= STAT_PENDING;
								send_q <= 1'b1;
								eidx_q <= 3'(free_q);
								osid_q <= req_q.target_sid;
								onet_q <= req_q.target_netid;
								oueid_q <= req_q.target_uid;
								oasid_q <= req_q.att_sid;
								oanet_q <= req_q.att_netid;
							end else begin
								eidx_q <= 3'(idx);
								osid_q <= sid_q[idx];
								onet_q <= net_q[idx];
								oueid_q <= ueid_q[idx];
								oasid_q <= asid_q[idx];
								oanet_q <= anet_q[idx];
								if (st_q[idx] == ST_QUERY) begin
									if (wait_q[idx] != 8'd0) begin
										stat_q <= STAT_PENDING;
									end else if (retry_q[idx] == 8'd0) begin
										wait_q[idx] <= qwait;
										stat_q <= STAT_PENDING;
										send_q <= 1'b1;
									end else begin
										stat_q <= STAT_DROP;
									end
								end else begin
									stat_q <= STAT_OK;
								end
							end
						end else if (req_q.func == FN_RESPONSE) begin
							if (!scan_end && st_q[idx] != ST_CACHED) begin
								st_q[idx] <= ST_CACHED;
								wait_q[idx] <= '0;
								ov_q <= 1'b1;
								last_q <= 1'b1;
								kind_q <= KIND_RESOLVED;
								stat_q <= STAT_OK;
								send_q <= 1'b0;
								eidx_q <= 3'(idx);
								if (hit_node) begin
									asid_q[idx] <= req_q.att_sid;
									anet_q[idx] <= req_q.att_netid;
									ueid_q[idx] <= req_q.target_uid;
									osid_q <= sid_q[idx];
									onet_q <= net_q[idx];
									oueid_q <= req_q.target_uid;
									oasid_q <= req_q.att_sid;
									oanet_q <= req_q.att_netid;
								end else begin
									sid_q[idx] <= req_q.target_sid;
									net_q[idx] <= req_q.target_netid;
									asid_q[idx] <= req_q.has_attach ?
										req_q.att_sid : inv_sid;
									anet_q[idx] <= req_q.has_attach ?
										req_q.att_netid : inv_net;
									osid_q <= req_q.target_sid;
									onet_q <= req_q.target_netid;
									oueid_q <= ueid_q[idx];
									oasid_q <= req_q.has_attach ?
										req_q.att_sid : inv_sid;
									oanet_q <= req_q.has_attach ?
										req_q.att_netid : inv_net;
								end
							end
						end else begin
							// Tick: release the held final timeout beat as last
							if (pend_q) begin
								ov_q <= 1'b1;
								last_q <= 1'b1;
								pend_q <= 1'b0;
								kind_q <= KIND_TIMEOUT;
								stat_q <= STAT_DROP;
								send_q <= 1'b0;
								eidx_q <= 3'(pidx_q);
								osid_q <= sid_q[pidx_q];
								onet_q <= net_q[pidx_q];
								oueid_q <= ueid_q[pidx_q];
								oasid_q <= asid_q[pidx_q];
								oanet_q <= anet_q[pidx_q];
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTH
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> state_q == BK_IDLE) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ready |=> ov_q) else $error("result beat lost");
	a_nout: assert property (@(posedge clk) disable iff (!arst_n)
		nout_q <= OutCntW'(MaxOut)) else $error("too many timeouts");
`endif

endmodule

FILE: src/address_resolver_cache_core.sv
// An item scans at most Entries entries, one a cycle unless a tick waits on a held beat.
// The back part works on one item at a time and takes no new one until it is done;
//   the table scan sets how long each item takes.
// A two-beat queue lets the front accept while the back works.
// Reset clears the whole table to invalid at once and loads default registers.
// Top level of the address resolver cache.
module address_resolver_cache_core
	import arc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	input logic lookup_key,
	input logic [15:0] target_sid,
	input logic [15:0] target_netid,
	input logic [63:0] target_uid,
	input logic [15:0] att_sid,
	input logic [15:0] att_netid,
	input logic has_attach,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] kind,
	output logic [1:0] status,
	output logic send_query,
	output logic [2:0] entry_index,
	output logic [15:0] out_target_sid,
	output logic [15:0] out_target_netid,
	output logic [63:0] out_target_uid,
	output logic [15:0] out_att_sid,
	output logic [15:0] out_att_netid,
	output logic last,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic [7:0] qwait_q, rwait_q;
	logic [15:0] inv_sid_q, inv_net_q;
	req_t in_req, q_req;
	logic q_valid, q_ready;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qwait_q <= 8'd3;
			rwait_q <= 8'd2;
			inv_sid_q <= 16'hFFFF;
			inv_net_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_QWAIT: qwait_q <= cfg_data[7:0];
				CFG_RWAIT: rwait_q <= cfg_data[7:0];
				CFG_INV_SID: inv_sid_q <= cfg_data;
				CFG_INV_NET: inv_net_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_req = '{func: func, lookup_key: lookup_key, target_sid: target_sid,
		target_netid: target_netid, target_uid: target_uid,
		att_sid: att_sid, att_netid: att_netid,
		has_attach: has_attach};

	arc_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.inv_sid(inv_sid_q), .inv_net(inv_net_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	arc_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.qwait(qwait_q), .rwait(rwait_q), .inv_sid(inv_sid_q), .inv_net(inv_net_q),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .status(status), .send_query(send_query),
		.entry_index(entry_index), .out_target_sid(out_target_sid),
		.out_target_netid(out_target_netid), .out_target_uid(out_target_uid),
		.out_att_sid(out_att_sid), .out_att_netid(out_att_netid),
		.last(last)
	);

endmodule
